// File: src/ldt_pkg.sv
// Shared types, command codes and helpers for the lock wait-for table.
package ldt_pkg;

	localparam int unsigned DEP_ENTRIES_DEF   = 64;
	localparam int unsigned CYCLE_ENTRIES_DEF = 16;
	localparam int unsigned ID_BITS_DEF       = 32;
	localparam int unsigned PORT_ID_BITS      = 32;

	typedef enum logic [2:0] {
		CMD_ADD     = 3'd0,
		CMD_REMOVE  = 3'd1,
		CMD_DETECT  = 3'd2,
		CMD_RESOLVE = 3'd3,
		CMD_READ    = 3'd4
	} cmd_t;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef struct packed {
		logic [2:0]              command;
		logic [PORT_ID_BITS-1:0] lock_key;
		logic [PORT_ID_BITS-1:0] holder_proc;
		logic [PORT_ID_BITS-1:0] waiter_proc;
		logic [7:0]              cycle_number;
	} req_t;

	typedef struct packed {
		logic                    status;
		logic [4:0]              cycles_found;
		logic [PORT_ID_BITS-1:0] cycle_holder;
		logic [PORT_ID_BITS-1:0] cycle_waiter;
		logic                    cycle_resolved;
		logic [6:0]              entries_used;
		logic [31:0]             deadlocks_total;
		logic [31:0]             resolutions_total;
	} rsp_t;

	// broadcast controls for the row of table cells
	typedef struct packed {
		logic write;
		logic mark;
		logic sweep;
		logic shift;
		logic load;
		logic rotate;
	} cell_ctrl_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

endpackage

// File: src/ldt_stream_if.sv
// Valid/ready channel carrying one word of a given payload type.
interface ldt_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/lock_wait_pair_deadlock_table_unit.sv
// Lock wait-for table with two-process deadlock detection, top level.
//
// Each request word carries one command and yields exactly one response word.
// Dependencies (lock, holder, waiter) live in a row of DEP_ENTRIES cells that
// stays compacted from index zero. Add, resolve and error commands finish in
// the cycle that accepts them; read passes through a read state, as the cycle
// record memory has a registered read. Remove: every cell compares its lock at
// once when the command is accepted, then in the sweep state the "first match
// at or before me" flag ripples down the row one cell per cycle, and the shift
// state moves the later cells down. Detect latches which cells are in use when
// it is accepted, then in the scan state the row rotates as a ring through all
// its cells, the head cell's entry is broadcast to all cells each cycle, and a
// swapped-pair hit records a cycle (up to CYCLE_ENTRIES) before the ring
// returns to its starting order. A new request is taken whenever the
// sequencer is idle and the response register is free or being drained.
// Totals saturate at all ones. Identifiers are kept to their low ID_BITS bits
// (at most 32) and zero-extended on the way out.
module lock_wait_pair_deadlock_table_unit #(
	parameter int unsigned DEP_ENTRIES   = ldt_pkg::DEP_ENTRIES_DEF,
	parameter int unsigned CYCLE_ENTRIES = ldt_pkg::CYCLE_ENTRIES_DEF,
	parameter int unsigned ID_BITS       = ldt_pkg::ID_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	ldt_stream_if.sink   req,
	ldt_stream_if.source rsp
);
	import ldt_pkg::*;

	localparam int unsigned IDW  = (ID_BITS < PORT_ID_BITS) ? ID_BITS : PORT_ID_BITS;
	localparam int unsigned UW   = $clog2(DEP_ENTRIES + 1);
	localparam int unsigned CW   = $clog2(DEP_ENTRIES);
	localparam int unsigned CUW  = $clog2(CYCLE_ENTRIES + 1);
	localparam int unsigned CIW  = (CYCLE_ENTRIES > 1) ? $clog2(CYCLE_ENTRIES) : 1;
	localparam int unsigned CMPW = (CUW > 8) ? CUW : 8;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SWEEP = 5'b00010,
		ST_SHIFT = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_READ  = 5'b10000
	} state_t;

	state_t         state_q, state_d;
	logic [CW-1:0]  cnt_q, cnt_d;
	logic [UW-1:0]  used_q, used_d;
	logic [CUW-1:0] cyc_used_q, cyc_used_d;
	logic [CUW-1:0] n_q, n_d;
	logic [31:0]    dl_q, dl_d;
	logic [31:0]    rs_q, rs_d;
	rsp_t           out_q;
	logic           out_valid_q;

	cell_ctrl_t     ctrl;
	logic           accept, fin, fin_status;
	logic [IDW-1:0] fin_holder, fin_waiter;
	logic           fin_done;
	logic           rec_en, res_en;

	// request fields, trimmed to identifier width
	logic [IDW-1:0] key_m, hold_m, wait_m;
	logic [7:0]     num_m1;
	logic [CIW-1:0] num_idx;
	logic           num_ok;

	// cell row
	logic [IDW-1:0]         c_lock [DEP_ENTRIES];
	logic [IDW-1:0]         c_hold [DEP_ENTRIES];
	logic [IDW-1:0]         c_wait [DEP_ENTRIES];
	logic [DEP_ENTRIES-1:0] c_vr, c_pre, c_match;

	logic [IDW-1:0] tb_holder, tb_waiter;
	logic           tb_done;

	assign key_m   = req.data.lock_key[IDW-1:0];
	assign hold_m  = req.data.holder_proc[IDW-1:0];
	assign wait_m  = req.data.waiter_proc[IDW-1:0];
	assign num_m1  = req.data.cycle_number - 8'd1;
	assign num_idx = num_m1[CIW-1:0];
	assign num_ok  = (req.data.cycle_number != 8'd0)
		&& (CMPW'(req.data.cycle_number) <= CMPW'(cyc_used_q));

	assign req.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	generate
		for (genvar k = 0; k < DEP_ENTRIES; k++) begin : g_cell
			localparam int unsigned NX = (k + 1) % DEP_ENTRIES;
			logic pre_prev;
			if (k == 0) begin : g_head
				assign pre_prev = 1'b0;
			end else begin : g_body
				assign pre_prev = c_pre[k-1];
			end
			ldt_cell #(.IDW(IDW)) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.wr_sel      (used_q == UW'(k)),
				.valid_in    (UW'(k) < used_q),
				.key         (key_m),
				.holder_in   (hold_m),
				.waiter_in   (wait_m),
				.head_holder (c_hold[0]),
				.head_waiter (c_wait[0]),
				.pre_prev    (pre_prev),
				.nxt_lock    (c_lock[NX]),
				.nxt_holder  (c_hold[NX]),
				.nxt_waiter  (c_wait[NX]),
				.nxt_vr      (c_vr[NX]),
				.lock        (c_lock[k]),
				.holder      (c_hold[k]),
				.waiter      (c_wait[k]),
				.vr          (c_vr[k]),
				.pre         (c_pre[k]),
				.match       (c_match[k])
			);
		end
	endgenerate

	ldt_cyc_tbl #(.CYCLE_ENTRIES(CYCLE_ENTRIES), .IDW(IDW)) u_tbl (
		.clk        (clk),
		.rec_en     (rec_en),
		.rec_idx    (n_q[CIW-1:0]),
		.rec_holder (c_hold[0]),
		.rec_waiter (c_wait[0]),
		.res_en     (res_en),
		.res_idx    (num_idx),
		.rd_idx     (num_idx),
		.rd_holder  (tb_holder),
		.rd_waiter  (tb_waiter),
		.rd_done    (tb_done)
	);

	// sequencer
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		used_d     = used_q;
		cyc_used_d = cyc_used_q;
		n_d        = n_q;
		dl_d       = dl_q;
		rs_d       = rs_q;
		ctrl       = '0;
		fin        = 1'b0;
		fin_status = STATUS_ERR;
		fin_holder = '0;
		fin_waiter = '0;
		fin_done   = 1'b0;
		rec_en     = 1'b0;
		res_en     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd_t'(req.data.command))
						CMD_ADD: begin
							fin = 1'b1;
							if (used_q != UW'(DEP_ENTRIES)) begin
								ctrl.write = 1'b1;
								used_d     = used_q + UW'(1);
								fin_status = STATUS_OK;
							end
						end
						CMD_REMOVE: begin
							if (key_m == '0) begin
								fin = 1'b1;
							end else begin
								ctrl.mark = 1'b1;
								cnt_d     = '0;
								state_d   = ST_SWEEP;
							end
						end
						CMD_DETECT: begin
							ctrl.load = 1'b1;
							cnt_d     = '0;
							n_d       = '0;
							state_d   = ST_SCAN;
						end
						CMD_RESOLVE: begin
							fin = 1'b1;
							if (num_ok) begin
								res_en     = 1'b1;
								rs_d       = sat_inc(rs_q);
								fin_status = STATUS_OK;
							end
						end
						CMD_READ: begin
							if (num_ok) begin
								state_d = ST_READ;
							end else begin
								fin = 1'b1;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			ST_SWEEP: begin
				ctrl.sweep = 1'b1;
				cnt_d      = cnt_q + CW'(1);
				if (cnt_q == CW'(DEP_ENTRIES - 1)) begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				// cells at or after the first match take their neighbor
				ctrl.shift = 1'b1;
				fin        = 1'b1;
				state_d    = ST_IDLE;
				if (c_pre[DEP_ENTRIES-1]) begin
					used_d     = used_q - UW'(1);
					fin_status = STATUS_OK;
				end
			end
			ST_SCAN: begin
				ctrl.rotate = 1'b1;
				cnt_d       = cnt_q + CW'(1);
				if (c_vr[0] && (|c_match) && (n_q < CUW'(CYCLE_ENTRIES))) begin
					rec_en = 1'b1;
					n_d    = n_q + CUW'(1);
					dl_d   = sat_inc(dl_q);
				end
				if (cnt_q == CW'(DEP_ENTRIES - 1)) begin
					cyc_used_d = n_d;
					fin        = 1'b1;
					fin_status = STATUS_OK;
					state_d    = ST_IDLE;
				end
			end
			ST_READ: begin
				fin        = 1'b1;
				fin_status = STATUS_OK;
				fin_holder = tb_holder;
				fin_waiter = tb_waiter;
				fin_done   = tb_done;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			used_q      <= '0;
			cyc_used_q  <= '0;
			n_q         <= '0;
			dl_q        <= '0;
			rs_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			used_q     <= used_d;
			cyc_used_q <= cyc_used_d;
			n_q        <= n_d;
			dl_q       <= dl_d;
			rs_q       <= rs_d;
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// response word: counters as they stand after the command
	always_ff @(posedge clk) begin
		if (fin) begin
			out_q.status            <= fin_status;
			out_q.cycles_found      <= 5'(cyc_used_d);
			out_q.cycle_holder      <= PORT_ID_BITS'(fin_holder);
			out_q.cycle_waiter      <= PORT_ID_BITS'(fin_waiter);
			out_q.cycle_resolved    <= fin_done;
			out_q.entries_used      <= 7'(used_d);
			out_q.deadlocks_total   <= dl_d;
			out_q.resolutions_total <= rs_d;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;
endmodule

// File: src/ldt_cell.sv
// One dependency table cell: holds an entry and trades it with its neighbor.
module ldt_cell #(
	parameter int unsigned IDW = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ldt_pkg::cell_ctrl_t ctrl,
	input  logic               wr_sel,
	input  logic               valid_in,
	input  logic [IDW-1:0]     key,
	input  logic [IDW-1:0]     holder_in,
	input  logic [IDW-1:0]     waiter_in,
	input  logic [IDW-1:0]     head_holder,
	input  logic [IDW-1:0]     head_waiter,
	input  logic               pre_prev,
	input  logic [IDW-1:0]     nxt_lock,
	input  logic [IDW-1:0]     nxt_holder,
	input  logic [IDW-1:0]     nxt_waiter,
	input  logic               nxt_vr,
	output logic [IDW-1:0]     lock,
	output logic [IDW-1:0]     holder,
	output logic [IDW-1:0]     waiter,
	output logic               vr,
	output logic               pre,
	output logic               match
);
	logic [IDW-1:0] lock_q, holder_q, waiter_q;
	logic           vr_q, hit_q, pre_q;

	always_ff @(posedge clk) begin
		if (ctrl.write && wr_sel) begin
			lock_q   <= key;
			holder_q <= holder_in;
			waiter_q <= waiter_in;
		end else if ((ctrl.shift && pre_q) || ctrl.rotate) begin
			lock_q   <= nxt_lock;
			holder_q <= nxt_holder;
			waiter_q <= nxt_waiter;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vr_q  <= 1'b0;
			hit_q <= 1'b0;
			pre_q <= 1'b0;
		end else begin
			if (ctrl.mark) begin
				hit_q <= valid_in && (lock_q == key);
				pre_q <= 1'b0;
			end
			// prefix of hits ripples one cell per cycle
			if (ctrl.sweep) begin
				pre_q <= pre_prev | hit_q;
			end
			if (ctrl.load) begin
				vr_q <= valid_in;
			end else if (ctrl.rotate) begin
				vr_q <= nxt_vr;
			end
		end
	end

	assign lock   = lock_q;
	assign holder = holder_q;
	assign waiter = waiter_q;
	assign vr     = vr_q;
	assign pre    = pre_q;
	assign match  = vr_q && (holder_q == head_waiter) && (waiter_q == head_holder);
endmodule

// File: src/ldt_cyc_tbl.sv
// Cycle record memory: holder, waiter and resolved flag per found cycle.
module ldt_cyc_tbl #(
	parameter int unsigned CYCLE_ENTRIES = 16,
	parameter int unsigned IDW           = 32,
	localparam int unsigned CIW = (CYCLE_ENTRIES > 1) ? $clog2(CYCLE_ENTRIES) : 1
) (
	input  logic           clk,
	input  logic           rec_en,
	input  logic [CIW-1:0] rec_idx,
	input  logic [IDW-1:0] rec_holder,
	input  logic [IDW-1:0] rec_waiter,
	input  logic           res_en,
	input  logic [CIW-1:0] res_idx,
	input  logic [CIW-1:0] rd_idx,
	output logic [IDW-1:0] rd_holder,
	output logic [IDW-1:0] rd_waiter,
	output logic           rd_done
);
	logic [IDW-1:0] hold_mem [CYCLE_ENTRIES];
	logic [IDW-1:0] wait_mem [CYCLE_ENTRIES];
	logic           done_mem [CYCLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (rec_en) begin
			hold_mem[rec_idx] <= rec_holder;
			wait_mem[rec_idx] <= rec_waiter;
		end
		if (rec_en) begin
			done_mem[rec_idx] <= 1'b0;
		end else if (res_en) begin
			done_mem[res_idx] <= 1'b1;
		end
		rd_holder <= hold_mem[rd_idx];
		rd_waiter <= wait_mem[rd_idx];
		rd_done   <= done_mem[rd_idx];
	end
endmodule

// File: src/ldt_checker.sv
// Port-level checks for the lock wait-for table, bound to the top level.
module ldt_checker #(
	parameter int unsigned DEP_ENTRIES   = ldt_pkg::DEP_ENTRIES_DEF,
	parameter int unsigned CYCLE_ENTRIES = ldt_pkg::CYCLE_ENTRIES_DEF
) (
	input logic          clk,
	input logic          arst_n,
	input logic          out_valid,
	input logic          out_ready,
	input ldt_pkg::rsp_t out_data
);
	import ldt_pkg::*;

	// hold a stalled response word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("response word changed while stalled");

	// a failed command never reports cycle contents
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == STATUS_ERR) |->
		(out_data.cycle_holder == '0) && (out_data.cycle_waiter == '0)
		&& !out_data.cycle_resolved)
		else $error("error response carries cycle data");

	a_cyc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(out_data.cycles_found) <= CYCLE_ENTRIES))
		else $error("cycle count beyond table size");

	a_dep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(out_data.entries_used) <= DEP_ENTRIES))
		else $error("entry count beyond table size");
endmodule

bind lock_wait_pair_deadlock_table_unit ldt_checker #(
	.DEP_ENTRIES   (DEP_ENTRIES),
	.CYCLE_ENTRIES (CYCLE_ENTRIES)
) u_ldt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.out_data  (rsp.data)
);

// File: tb/ldt_table_checker.sv
// Checker for the lock wait-for table: tracks the table, predicts each response word, compares.
`timescale 1ns / 1ps
module ldt_table_checker (
	input  logic clk,
	input  logic arst_n,
	ldt_stream_if req,
	ldt_stream_if rsp,
	output int   fail_count,
	output int   pending,
	output int   checked,
	output int   most_cycles,
	output int   full_hits
);
	import ldt_pkg::*;

	localparam int unsigned DEPS = DEP_ENTRIES_DEF;
	localparam int unsigned CYCS = CYCLE_ENTRIES_DEF;

	logic [31:0] dep_lock_m   [DEPS];
	logic [31:0] dep_holder_m [DEPS];
	logic [31:0] dep_waiter_m [DEPS];
	int unsigned dep_count;
	logic [31:0] cyc_holder_m [CYCS];
	logic [31:0] cyc_waiter_m [CYCS];
	logic        cyc_done_m   [CYCS];
	int unsigned cyc_count;
	logic [31:0] deadlock_sum;
	logic [31:0] resolve_sum;
	rsp_t        rsp_queue[$];

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	// advance the model table by one request and return the response it produces
	function rsp_t apply_request(input req_t r);
		rsp_t o;
		logic ok;
		int   n;
		bit   hit;
		o = '0;
		ok = 1'b0;
		case (r.command)
			CMD_ADD: begin
				if (dep_count < DEPS) begin
					dep_lock_m[dep_count] = r.lock_key;
					dep_holder_m[dep_count] = r.holder_proc;
					dep_waiter_m[dep_count] = r.waiter_proc;
					dep_count++;
					ok = 1'b1;
				end else begin
					full_hits++;
				end
			end
			CMD_REMOVE: begin
				if (r.lock_key != 0) begin
					for (int i = 0; i < dep_count && !ok; i++) begin
						if (dep_lock_m[i] == r.lock_key) begin
							for (int k = i; k + 1 < dep_count; k++) begin
								dep_lock_m[k] = dep_lock_m[k+1];
								dep_holder_m[k] = dep_holder_m[k+1];
								dep_waiter_m[k] = dep_waiter_m[k+1];
							end
							dep_count--;
							ok = 1'b1;
						end
					end
				end
			end
			CMD_DETECT: begin
				n = 0;
				for (int i = 0; i < dep_count && n < CYCS; i++) begin
					hit = 0;
					for (int j = 0; j < dep_count && !hit; j++) begin
						if (dep_holder_m[j] == dep_waiter_m[i] &&
						    dep_waiter_m[j] == dep_holder_m[i]) begin
							cyc_holder_m[n] = dep_holder_m[i];
							cyc_waiter_m[n] = dep_waiter_m[i];
							cyc_done_m[n] = 1'b0;
							n++;
							deadlock_sum = bump(deadlock_sum);
							hit = 1;
						end
					end
				end
				cyc_count = n;
				if (n > most_cycles)
					most_cycles = n;
				ok = 1'b1;
			end
			CMD_RESOLVE: begin
				if (r.cycle_number != 0 && r.cycle_number <= cyc_count) begin
					cyc_done_m[r.cycle_number-1] = 1'b1;
					resolve_sum = bump(resolve_sum);
					ok = 1'b1;
				end
			end
			CMD_READ: begin
				if (r.cycle_number != 0 && r.cycle_number <= cyc_count) begin
					o.cycle_holder = cyc_holder_m[r.cycle_number-1];
					o.cycle_waiter = cyc_waiter_m[r.cycle_number-1];
					o.cycle_resolved = cyc_done_m[r.cycle_number-1];
					ok = 1'b1;
				end
			end
			default: ;
		endcase
		o.status = ok ? STATUS_OK : STATUS_ERR;
		o.cycles_found = 5'(cyc_count);
		o.entries_used = 7'(dep_count);
		o.deadlocks_total = deadlock_sum;
		o.resolutions_total = resolve_sum;
		return o;
	endfunction

	task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		rsp_t got;
		if (!arst_n) begin
			dep_count = 0;
			cyc_count = 0;
			deadlock_sum = '0;
			resolve_sum = '0;
			fail_count = 0;
			checked = 0;
			most_cycles = 0;
			full_hits = 0;
			rsp_queue.delete();
			pending <= 0;
		end else begin
			if (req.valid && req.ready)
				rsp_queue.push_back(apply_request(req.data));
			if (rsp.valid && rsp.ready) begin
				got = rsp.data;
				checked++;
				if (rsp_queue.size() == 0) begin
					$display("%0t: unexpected response word %h", $time, got);
					fail_count++;
				end else begin
					want = rsp_queue.pop_front();
					report("status", 32'(want.status), 32'(got.status));
					report("cycles_found", 32'(want.cycles_found), 32'(got.cycles_found));
					report("cycle_holder", want.cycle_holder, got.cycle_holder);
					report("cycle_waiter", want.cycle_waiter, got.cycle_waiter);
					report("cycle_resolved", 32'(want.cycle_resolved),
						32'(got.cycle_resolved));
					report("entries_used", 32'(want.entries_used), 32'(got.entries_used));
					report("deadlocks_total", want.deadlocks_total, got.deadlocks_total);
					report("resolutions_total", want.resolutions_total,
						got.resolutions_total);
				end
			end
			pending <= rsp_queue.size();
		end
	end

endmodule

// File: tb/tb_lock_wait_pair_deadlock_table_unit.sv
// Testbench top: stimulus, idling and verdict for the lock wait-for table.
`timescale 1ns / 1ps
module tb_lock_wait_pair_deadlock_table_unit;
	import ldt_pkg::*;

	localparam int RANDOM_WORDS = 1880;
	localparam int CALM_WORDS   = 200;

	logic clk;
	logic arst_n;
	int   fail_count, pending, checked, most_cycles, full_hits;
	int   sent;
	bit   calm;
	int   mode;

	ldt_stream_if #(.payload_t(req_t)) req_ch ();
	ldt_stream_if #(.payload_t(rsp_t)) rsp_ch ();

	lock_wait_pair_deadlock_table_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	ldt_table_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fail_count  (fail_count),
		.pending     (pending),
		.checked     (checked),
		.most_cycles (most_cycles),
		.full_hits   (full_hits)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#4ms;
		$display("lock_wait_pair_deadlock_table_unit regression: fail");
		$finish;
	end

	// response side: hold ready low in random bursts, never once calm
	initial begin
		int stall;
		stall = 0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				rsp_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall = $urandom_range(1, 13) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// present one word and hold it until the block takes it
	task automatic send_word(input req_t w);
		req_ch.valid <= 1'b1;
		req_ch.data <= w;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sent++;
	endtask

	// drop valid for a random burst
	task automatic sender_gap();
		int n;
		n = $urandom_range(1, 13);
		req_ch.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic req_t make_word(input cmd_t c, input logic [31:0] lk,
		input logic [31:0] h, input logic [31:0] w, input logic [7:0] num);
		req_t r;
		r.command = c;
		r.lock_key = lk;
		r.holder_proc = h;
		r.waiter_proc = w;
		r.cycle_number = num;
		return r;
	endfunction

	function automatic logic [31:0] pick_lock();
		int p;
		p = $urandom_range(0, 99);
		if (p < 70) return 32'($urandom_range(0, 7));
		if (p < 80) return (p & 1) ? 32'hFFFF_FFFF : 32'h0;
		return $urandom;
	endfunction

	// small pools of process ids make swapped pairs and self waits common
	function automatic logic [31:0] pick_proc(input bit tight);
		if ($urandom_range(0, 9) < 8)
			return 32'($urandom_range(0, tight ? 3 : 6));
		return $urandom;
	endfunction

	function automatic req_t random_word();
		req_t r;
		int   p;
		int   add_w;
		p = $urandom_range(0, 99);
		// fill mode keeps the table near full, drain mode empties it
		add_w = (mode == 0) ? 55 : (mode == 1) ? 30 : 10;
		r.lock_key = pick_lock();
		r.holder_proc = pick_proc(mode == 0);
		r.waiter_proc = pick_proc(mode == 0);
		r.cycle_number = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 17))
			: 8'($urandom_range(0, 255));
		if (p < add_w) r.command = CMD_ADD;
		else if (p < add_w + 20 + (mode == 2 ? 25 : 0)) r.command = CMD_REMOVE;
		else if (p < 85) r.command = CMD_DETECT;
		else if (p < 91) r.command = CMD_RESOLVE;
		else if (p < 98) r.command = CMD_READ;
		else r.command = cmd_t'($urandom_range(5, 7));
		return r;
	endfunction

	initial begin
		int spins;
		calm = 0;
		mode = 0;
		sent = 0;
		arst_n = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table errors, zero lock, pairs, self wait, duplicates
		send_word(make_word(CMD_REMOVE, 32'h0, 32'h0, 32'h0, 8'd0));
		send_word(make_word(CMD_REMOVE, 32'h5, 32'h0, 32'h0, 8'd0));
		send_word(make_word(CMD_READ, 32'h0, 32'h0, 32'h0, 8'd1));
		send_word(make_word(CMD_RESOLVE, 32'h0, 32'h0, 32'h0, 8'd0));
		send_word(make_word(CMD_DETECT, 32'h0, 32'h0, 32'h0, 8'd0));
		send_word(make_word(CMD_ADD, 32'h0, 32'hFFFF_FFFF, 32'h0, 8'd0));
		send_word(make_word(CMD_ADD, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 8'hFF));
		send_word(make_word(CMD_ADD, 32'h7, 32'hA5A5_5A5A, 32'hA5A5_5A5A, 8'd0));
		send_word(make_word(CMD_ADD, 32'h7, 32'h1, 32'h2, 8'd0));
		send_word(make_word(CMD_DETECT, 32'h0, 32'h0, 32'h0, 8'd0));
		send_word(make_word(CMD_READ, 32'h0, 32'h0, 32'h0, 8'd1));
		send_word(make_word(CMD_READ, 32'h0, 32'h0, 32'h0, 8'd3));
		send_word(make_word(CMD_READ, 32'h0, 32'h0, 32'h0, 8'd4));
		send_word(make_word(CMD_READ, 32'h0, 32'h0, 32'h0, 8'hFF));
		send_word(make_word(CMD_RESOLVE, 32'h0, 32'h0, 32'h0, 8'd2));
		send_word(make_word(CMD_RESOLVE, 32'h0, 32'h0, 32'h0, 8'd2));
		send_word(make_word(CMD_RESOLVE, 32'h0, 32'h0, 32'h0, 8'd0));
		send_word(make_word(CMD_READ, 32'h0, 32'h0, 32'h0, 8'd2));
		send_word(make_word(CMD_REMOVE, 32'h7, 32'h0, 32'h0, 8'd0));
		send_word(make_word(CMD_REMOVE, 32'h0, 32'h0, 32'h0, 8'd0));
		send_word(make_word(cmd_t'(3'd5), 32'h7, 32'h1, 32'h2, 8'd1));
		send_word(make_word(cmd_t'(3'd6), 32'h0, 32'h0, 32'h0, 8'd1));
		send_word(make_word(cmd_t'(3'd7), 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 8'hFF));

		// random: cycle through fill, mixed and drain phases
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 150 == 0)
				mode = (i / 150) % 3;
			if (i == RANDOM_WORDS - CALM_WORDS)
				calm = 1;
			send_word(random_word());
			// hold off once until the block has answered everything
			if (i == RANDOM_WORDS / 2) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				sender_gap();
			end
		end
		req_ch.valid <= 1'b0;

		spins = 0;
		while (pending != 0 && spins < 20000) begin
			@(posedge clk);
			spins++;
		end
		repeat (100) @(posedge clk);

		$display("Sent %0d request words, checked %0d responses; most cycles in one detect %0d,",
			sent, checked, most_cycles);
		$display("full-table adds refused %0d, words still owed %0d.", full_hits, pending);
		if (fail_count == 0 && pending == 0)
			$display("lock_wait_pair_deadlock_table_unit regression: pass");
		else
			$display("lock_wait_pair_deadlock_table_unit regression: fail");
		$finish;
	end

endmodule
